// ===== hw/rtl/gtd_pkg.sv =====
// Shared types and constants of the Goertzel tone detector.
package gtd_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 16;
	localparam int RATIO_W    = 16;
	localparam int STATE_W    = 48;
	localparam int ENERGY_W   = 48;
	localparam int OUT_W      = 64;
	localparam int MUL_D_W    = 17;
	localparam int PROD_W     = STATE_W + MUL_D_W;
	localparam int ACC_W      = 112;
	localparam int OPND_W     = 64;
	localparam int CHUNK_W    = 16;
	localparam int GAIN_W     = OUT_W + RATIO_W;
	localparam int MAC_STEPS  = 8;
	localparam int SNAP_DEPTH = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [COEF_W-1:0]  COEF_RESET  = 16'd17121;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd3146;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TONE_COEF  = 1'b0,
		CFG_RATIO_GAIN = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [STATE_W-1:0]  s1;
		logic [STATE_W-1:0]  s2;
		logic [ENERGY_W-1:0] energy;
	} snapshot_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_PRE   = 8'b0000_0010,
		ST_UCALC = 8'b0000_0100,
		ST_MAC   = 8'b0000_1000,
		ST_DRAIN = 8'b0001_0000,
		ST_SAT   = 8'b0010_0000,
		ST_GAIN  = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} back_state_t;

endpackage

// ===== hw/rtl/gtd_front.sv =====
// Sample front end: Goertzel recurrence, energy sum and frame end detection.
module gtd_front #(
	parameter int MAX_FRAME = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic [gtd_pkg::SAMPLE_W-1:0]      sample,
	input  logic                              last_sample,
	input  logic [gtd_pkg::COEF_W-1:0]        tone_coef,
	input  gtd_pkg::fifo_status_t             fifo_stat,
	output logic                              snap_push,
	output gtd_pkg::snapshot_t                snap
);

	localparam int CNT_W = (MAX_FRAME > 2) ? $clog2(MAX_FRAME) : 1;
	localparam int SW    = gtd_pkg::STATE_W;
	localparam int EW    = gtd_pkg::ENERGY_W;

	logic [SW-1:0]    s1_q, s2_q;
	logic [EW-1:0]    esum_q;
	logic [CNT_W-1:0] count_q;

	logic               accept, frame_end;
	logic signed [63:0] cprod, rnd, qv, sum;
	logic [SW-1:0]      s_new;
	logic signed [31:0] xsq;
	logic [EW:0]        esum_add;
	logic [EW-1:0]      esum_new;

	assign accept = push && !fifo_stat.full;
	assign frame_end = last_sample || (count_q == CNT_W'(MAX_FRAME - 1));

	assign cprod = $signed(tone_coef) * $signed(s1_q);
	assign rnd   = cprod + 64'sd8192;
	assign qv    = rnd >>> 14;
	assign sum   = 64'($signed(sample)) + qv - 64'($signed(s2_q));

	always_comb begin
		if (sum[63:SW-1] == '0 || sum[63:SW-1] == '1) begin
			s_new = sum[SW-1:0];
		end else if (sum[63]) begin
			s_new = {1'b1, {(SW-1){1'b0}}};
		end else begin
			s_new = {1'b0, {(SW-1){1'b1}}};
		end
	end

	assign xsq      = $signed(sample) * $signed(sample);
	assign esum_add = {1'b0, esum_q} + (EW+1)'(unsigned'(xsq));
	assign esum_new = esum_add[EW] ? '1 : esum_add[EW-1:0];

	assign snap_push   = accept && frame_end;
	assign snap.s1     = s_new;
	assign snap.s2     = s1_q;
	assign snap.energy = esum_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q    <= '0;
			s2_q    <= '0;
			esum_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				s1_q    <= '0;
				s2_q    <= '0;
				esum_q  <= '0;
				count_q <= '0;
			end else begin
				s1_q    <= s_new;
				s2_q    <= s1_q;
				esum_q  <= esum_new;
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/gtd_snap_fifo.sv =====
// Short queue of end-of-frame snapshots between front end and energy unit.
module gtd_snap_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr,
	input  gtd_pkg::snapshot_t    wr_data,
	input  logic                  rd,
	output gtd_pkg::snapshot_t    rd_data,
	output gtd_pkg::fifo_status_t stat
);

	localparam int DEPTH = gtd_pkg::SNAP_DEPTH;
	localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	gtd_pkg::snapshot_t mem_q [DEPTH];
	logic [PTR_W-1:0]   wptr_q, rptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr, do_rd;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_wr      = wr && !stat.full;
	assign do_rd      = rd && !stat.empty;
	assign rd_data    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/gtd_back.sv =====
// Energy unit: tone power via shared multiplier, detect compare, result register.
module gtd_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  gtd_pkg::fifo_status_t            fifo_stat,
	input  gtd_pkg::snapshot_t               head,
	output logic                             snap_pop,
	input  logic [gtd_pkg::COEF_W-1:0]       tone_coef,
	input  logic [gtd_pkg::RATIO_W-1:0]      ratio_gain,
	input  logic                             pop,
	output logic                             empty,
	output logic                             tone_present,
	output logic [gtd_pkg::OUT_W-1:0]        tone_energy,
	output logic [gtd_pkg::OUT_W-1:0]        total_energy
);

	localparam int SW = gtd_pkg::STATE_W;
	localparam int PW = gtd_pkg::PROD_W;
	localparam int AW = gtd_pkg::ACC_W;
	localparam int OW = gtd_pkg::OPND_W;
	localparam int CW = gtd_pkg::CHUNK_W;
	localparam int DW = gtd_pkg::MUL_D_W;
	localparam int TW = gtd_pkg::OUT_W;
	localparam int GW = gtd_pkg::GAIN_W;

	gtd_pkg::back_state_t state_q;

	logic [SW-1:0]                s1_q, s2_q;
	logic [gtd_pkg::ENERGY_W-1:0] e_q;
	logic [OW-1:0]                u_q;
	logic [PW-1:0]                prod_q;
	logic                         pvalid_q, pshift_q;
	logic [AW-1:0]                acc_q;
	logic [2:0]                   step_q;
	logic [TW-1:0]                tone_q;
	logic [GW-1:0]                lhs_q;
	logic                         out_valid_q;

	logic signed [SW-1:0] mul_a;
	logic signed [DW-1:0] mul_d;
	logic signed [PW-1:0] mul_p;
	logic [OW-1:0]        v_w, opnd;
	logic [1:0]           ci;
	logic [CW-1:0]        chunk;
	logic [OW+1:0]        u_w;
	logic [AW-1:0]        acc_base;
	logic [TW-1:0]        tone_w;
	logic                 detect, res_load;

	assign v_w   = {{2{s2_q[SW-1]}}, s2_q, 14'b0};
	assign ci    = 2'd3 - step_q[2:1];
	assign opnd  = step_q[0] ? v_w : u_q;
	assign chunk = opnd[{ci, 4'b0} +: CW];

	always_comb begin
		if (state_q == gtd_pkg::ST_MAC) begin
			mul_a = step_q[0] ? s2_q : s1_q;
			mul_d = (ci == 2'd3) ? {chunk[CW-1], chunk} : {1'b0, chunk};
		end else begin
			mul_a = s2_q;
			mul_d = {tone_coef[gtd_pkg::COEF_W-1], tone_coef};
		end
	end

	assign mul_p    = mul_a * mul_d;
	assign u_w      = {{4{s1_q[SW-1]}}, s1_q, 14'b0} - {prod_q[PW-1], prod_q};
	assign acc_base = pshift_q ? {acc_q[AW-CW-1:0], {CW{1'b0}}} : acc_q;
	assign tone_w   = (acc_q[AW-1:TW+14] != '0) ? '1 : acc_q[TW+13:14];
	assign detect   = lhs_q > {{(GW-gtd_pkg::ENERGY_W-16){1'b0}}, e_q, 16'b0};
	assign res_load = (state_q == gtd_pkg::ST_DONE) && !out_valid_q;
	assign snap_pop = (state_q == gtd_pkg::ST_IDLE) && !fifo_stat.empty;
	assign empty    = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gtd_pkg::ST_IDLE;
			step_q      <= '0;
			pvalid_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				gtd_pkg::ST_IDLE: begin
					if (!fifo_stat.empty) begin
						state_q <= gtd_pkg::ST_PRE;
					end
				end
				gtd_pkg::ST_PRE: begin
					state_q <= gtd_pkg::ST_UCALC;
				end
				gtd_pkg::ST_UCALC: begin
					step_q  <= '0;
					state_q <= gtd_pkg::ST_MAC;
				end
				gtd_pkg::ST_MAC: begin
					pvalid_q <= 1'b1;
					step_q   <= step_q + 1'b1;
					if (step_q == 3'(gtd_pkg::MAC_STEPS - 1)) begin
						state_q <= gtd_pkg::ST_DRAIN;
					end
				end
				gtd_pkg::ST_DRAIN: begin
					pvalid_q <= 1'b0;
					state_q  <= gtd_pkg::ST_SAT;
				end
				gtd_pkg::ST_SAT: begin
					state_q <= gtd_pkg::ST_GAIN;
				end
				gtd_pkg::ST_GAIN: begin
					state_q <= gtd_pkg::ST_DONE;
				end
				gtd_pkg::ST_DONE: begin
					if (!out_valid_q) begin
						state_q <= gtd_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= gtd_pkg::ST_IDLE;
				end
			endcase
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap_pop) begin
			s1_q <= head.s1;
			s2_q <= head.s2;
			e_q  <= head.energy;
		end
		if (state_q == gtd_pkg::ST_PRE || state_q == gtd_pkg::ST_MAC) begin
			prod_q   <= mul_p;
			pshift_q <= !step_q[0] && (state_q == gtd_pkg::ST_MAC);
		end
		if (state_q == gtd_pkg::ST_UCALC) begin
			u_q   <= u_w[OW-1:0];
			acc_q <= '0;
		end else if (pvalid_q) begin
			acc_q <= acc_base + {{(AW-PW){prod_q[PW-1]}}, prod_q};
		end
		if (state_q == gtd_pkg::ST_SAT) begin
			tone_q <= tone_w;
		end
		if (state_q == gtd_pkg::ST_GAIN) begin
			lhs_q <= tone_q * ratio_gain;
		end
		if (res_load) begin
			tone_present <= detect;
			tone_energy  <= tone_q;
			total_energy <= TW'(e_q);
		end
	end

	a_acc_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gtd_pkg::ST_SAT |-> !acc_q[AW-1])
		else $error("tone power accumulator negative");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(tone_energy))
		else $error("pending result overwritten");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		snap_pop |=> state_q == gtd_pkg::ST_PRE)
		else $error("snapshot taken outside idle");

	a_detect_tone: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && detect |-> tone_q != '0)
		else $error("tone flagged with zero tone energy");

endmodule

// ===== hw/rtl/goertzel_tone_detector_unit.sv =====
// Top level of the Goertzel tone detector: config registers and block wiring.
//
//  channel   direction  handshake                transaction
//  sample    in         push / full              sample, last_sample
//  result    out        empty / pop              tone_present, tone_energy, total_energy
//  config    in         cfg_write                cfg_index, cfg_data
//
// One sample per cycle while full is low; full rises only while two finished frames wait for the energy unit.
// Each frame end passes through the energy unit in order: snapshot pop, coefficient product, setup,
// the 8-step multiply sequence on its shared 48x17 multiplier, drain, saturate, gain, compare.
// Reset clears recurrence state, queue and result valid flag; config returns to defaults.
// A result waiting on pop stalls the energy unit only; samples keep flowing until the queue fills.
module goertzel_tone_detector_unit #(
	parameter int MAX_FRAME = 128
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [gtd_pkg::SAMPLE_W-1:0]        sample,
	input  logic                                last_sample,
	output logic                                empty,
	input  logic                                pop,
	output logic                                tone_present,
	output logic [gtd_pkg::OUT_W-1:0]           tone_energy,
	output logic [gtd_pkg::OUT_W-1:0]           total_energy,
	input  logic                                cfg_write,
	input  logic [gtd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gtd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [gtd_pkg::COEF_W-1:0]  tone_coef_q;
	logic [gtd_pkg::RATIO_W-1:0] ratio_gain_q;

	gtd_pkg::fifo_status_t fifo_stat;
	gtd_pkg::snapshot_t    snap, head;
	logic                  snap_push, snap_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_coef_q  <= gtd_pkg::COEF_RESET;
			ratio_gain_q <= gtd_pkg::RATIO_RESET;
		end else if (cfg_write) begin
			unique case (gtd_pkg::cfg_index_t'(cfg_index))
				gtd_pkg::CFG_TONE_COEF:  tone_coef_q  <= cfg_data[gtd_pkg::COEF_W-1:0];
				gtd_pkg::CFG_RATIO_GAIN: ratio_gain_q <= cfg_data[gtd_pkg::RATIO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign full = fifo_stat.full;

	gtd_front #(
		.MAX_FRAME(MAX_FRAME)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.sample     (sample),
		.last_sample(last_sample),
		.tone_coef  (tone_coef_q),
		.fifo_stat  (fifo_stat),
		.snap_push  (snap_push),
		.snap       (snap)
	);

	gtd_snap_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (snap_push),
		.wr_data(snap),
		.rd     (snap_pop),
		.rd_data(head),
		.stat   (fifo_stat)
	);

	gtd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fifo_stat   (fifo_stat),
		.head        (head),
		.snap_pop    (snap_pop),
		.tone_coef   (tone_coef_q),
		.ratio_gain  (ratio_gain_q),
		.pop         (pop),
		.empty       (empty),
		.tone_present(tone_present),
		.tone_energy (tone_energy),
		.total_energy(total_energy)
	);

endmodule

// ===== dv/goertzel_tone_detector_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the Goertzel tone detector: directed and random frames checked against a frame-level predictor.
module goertzel_tone_detector_unit_tb;

	localparam int FRAME_LIMIT = 128;
	localparam int PHASE_SAMPLES = 70;
	localparam int SETTLE_CYCLES = 64;

	typedef struct {
		logic        present;
		logic [63:0] tone;
		logic [63:0] total;
	} frame_energy_t;

	class tone_frame_scoreboard;
		logic signed [15:0] coef;
		logic [15:0]        ratio;
		logic signed [47:0] s1;
		logic signed [47:0] s2;
		logic [47:0]        esum;
		int unsigned        frame_len;
		frame_energy_t      pending_frames[$];
		int unsigned        n_errors;
		int unsigned        n_samples;
		int unsigned        n_frames;
		int unsigned        n_detects;

		function new();
			coef = gtd_pkg::COEF_RESET;
			ratio = gtd_pkg::RATIO_RESET;
			s1 = '0;
			s2 = '0;
			esum = '0;
			frame_len = 0;
			n_errors = 0;
			n_samples = 0;
			n_frames = 0;
			n_detects = 0;
		endfunction

		function void note_sample(logic signed [15:0] x, logic last);
			logic signed [65:0]  prod;
			logic signed [65:0]  upd;
			logic signed [47:0]  s_next;
			logic [47:0]         xsq;
			logic [48:0]         esum_next;
			logic signed [131:0] a;
			logic signed [131:0] b;
			logic signed [131:0] t;
			logic [95:0]         lhs;
			frame_energy_t       res;

			prod = coef * s1;
			prod = prod + 66'sd8192;
			upd = x + (prod >>> 14) - s2;
			if (upd[65:47] != {19{upd[65]}})
				s_next = upd[65] ? {1'b1, 47'h0} : {1'b0, {47{1'b1}}};
			else
				s_next = upd[47:0];
			xsq = x * x;
			esum_next = {1'b0, esum} + xsq;
			esum = esum_next[48] ? '1 : esum_next[47:0];
			s2 = s1;
			s1 = s_next;
			frame_len++;
			n_samples++;
			if (!last && frame_len < FRAME_LIMIT)
				return;

			// exact tone power, floor division by 2^14, saturated to 64 bits
			a = s1;
			b = s2;
			t = ((a * a + b * b) <<< 14) - coef * a * b;
			t = t >>> 14;
			res.tone = (|t[131:64]) ? '1 : t[63:0];
			res.total = {16'h0, esum};
			lhs = res.tone * ratio;
			res.present = lhs > {32'h0, esum, 16'h0};
			pending_frames.push_back(res);
			s1 = '0;
			s2 = '0;
			esum = '0;
			frame_len = 0;
		endfunction

		function void check_result(logic present, logic [63:0] tone, logic [63:0] total);
			frame_energy_t exp_res;

			if (pending_frames.size() == 0) begin
				$error("result transaction with no frame pending");
				n_errors++;
				return;
			end
			exp_res = pending_frames.pop_front();
			n_frames++;
			if (exp_res.present)
				n_detects++;
			if (present !== exp_res.present) begin
				$error("tone_present: expected %0d, got %0d", exp_res.present, present);
				n_errors++;
			end
			if (tone !== exp_res.tone) begin
				$error("tone_energy: expected %0d, got %0d", exp_res.tone, tone);
				n_errors++;
			end
			if (total !== exp_res.total) begin
				$error("total_energy: expected %0d, got %0d", exp_res.total, total);
				n_errors++;
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           push;
	logic                           full;
	logic [gtd_pkg::SAMPLE_W-1:0]   sample;
	logic                           last_sample;
	logic                           empty;
	logic                           pop;
	logic                           tone_present;
	logic [gtd_pkg::OUT_W-1:0]      tone_energy;
	logic [gtd_pkg::OUT_W-1:0]      total_energy;
	logic                           cfg_write;
	gtd_pkg::cfg_index_t            cfg_index;
	logic [gtd_pkg::CFG_DATA_W-1:0] cfg_data;

	tone_frame_scoreboard sb;
	bit                   tx_gaps;
	bit                   rx_gaps;
	int unsigned          n_settings;

	goertzel_tone_detector_unit #(
		.MAX_FRAME(FRAME_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample(sample),
		.last_sample(last_sample),
		.empty(empty),
		.pop(pop),
		.tone_present(tone_present),
		.tone_energy(tone_energy),
		.total_energy(total_energy),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_sample(input logic [15:0] x, input logic last);
		while (tx_gaps && $urandom_range(99) < 16) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		sample <= x;
		last_sample <= last;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_sample(x, last);
		@(negedge clk);
	endtask

	// kinds: 0 tone, 1 full-range noise, 2 low-level noise, 3 extremes, 4 tone plus noise
	task automatic send_frame(input int kind, input int len);
		longint y0;
		longint y1;
		longint y2;
		longint v;
		logic [15:0] x;

		y2 = 0;
		y1 = $urandom_range(20000, 500);
		for (int i = 0; i < len; i++) begin
			y0 = ((longint'(sb.coef) * y1 + 8192) >>> 14) - y2;
			if (y0 > 32767)
				y0 = 32767;
			if (y0 < -32768)
				y0 = -32768;
			y2 = y1;
			y1 = y0;
			case (kind)
				0: v = y0;
				1: v = $signed(16'($urandom()));
				2: v = longint'($urandom_range(64)) - 32;
				3: begin
					case ($urandom_range(3))
						0: v = 32767;
						1: v = -32768;
						2: v = 0;
						default: v = -1;
					endcase
				end
				default: v = y0 + longint'($urandom_range(4000)) - 2000;
			endcase
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			x = v[15:0];
			send_sample(x, i == len - 1);
		end
	endtask

	task automatic send_random_frame();
		int r;
		int len;

		r = $urandom_range(99);
		if (r < 5)
			len = 1;
		else if (r < 10)
			len = FRAME_LIMIT;
		else if (r < 15)
			len = $urandom_range(FRAME_LIMIT + 12, FRAME_LIMIT + 1);
		else if (r < 30)
			len = $urandom_range(FRAME_LIMIT, 25);
		else
			len = $urandom_range(24, 2);
		send_frame($urandom_range(4), len);
	endtask

	task automatic configure(input logic [15:0] coef, input logic [15:0] ratio);
		push <= 1'b0;
		while (sb.pending_frames.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= gtd_pkg::CFG_TONE_COEF;
		cfg_data <= coef;
		@(negedge clk);
		cfg_index <= gtd_pkg::CFG_RATIO_GAIN;
		cfg_data <= ratio;
		@(negedge clk);
		cfg_write <= 1'b0;
		sb.coef = coef;
		sb.ratio = ratio;
		n_settings++;
	endtask

	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			pop <= !(rx_gaps && $urandom_range(99) < 16);
			@(posedge clk);
			if (pop && !empty)
				sb.check_result(tone_present, tone_energy, total_energy);
		end
	end

	initial begin
		int unsigned start;
		logic [15:0] coef;
		logic [15:0] ratio;

		sb = new();
		arst_n = 1'b0;
		push = 1'b0;
		sample = '0;
		last_sample = 1'b0;
		cfg_write = 1'b0;
		cfg_index = gtd_pkg::CFG_TONE_COEF;
		cfg_data = '0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		n_settings = 1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed frames at reset configuration
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8000, 1'b1);
		send_sample(16'h8000, 1'b1);
		send_sample(16'h0000, 1'b0);
		send_sample(16'h0000, 1'b1);
		send_sample(16'h5555, 1'b0);
		send_sample(16'hAAAA, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0001, 1'b1);
		send_frame(0, 12);

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: ;
				1: configure(16'h8000, 16'hFFFF);
				2: configure(16'h7FFF, 16'h0000);
				3: configure(16'h0000, gtd_pkg::RATIO_RESET);
				4: configure(gtd_pkg::COEF_RESET, 16'h0001);
				default: begin
					coef = $urandom();
					ratio = $urandom();
					configure(coef, ratio);
				end
			endcase
			tx_gaps = (phase != 4);
			rx_gaps = (phase != 4);
			start = sb.n_samples;
			while (sb.n_samples - start < PHASE_SAMPLES)
				send_random_frame();
		end
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;

		push <= 1'b0;
		while (sb.pending_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d samples, %0d frame results (%0d with tone) over %0d settings",
			sb.n_samples, sb.n_frames, sb.n_detects, n_settings);
		if (sb.n_errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
